// ----- design/vvau_pkg.sv -----
// Shared types, constants and saturating arithmetic helpers for the Verlet axis update.
`timescale 1ns / 1ps

package vvau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int TS_W       = 20;
   localparam int SCALE_W    = 18;
   localparam int LIM_W      = 21;
   localparam int DTM_W      = 24;
   localparam int COEF_W     = 32;
   localparam int RAWCOEF_W  = TS_W + DTM_W;
   localparam int PROD_W     = DATA_WIDTH + COEF_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VSCALE_X   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_VSCALE_Y   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_VSCALE_Z   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OFFSET = CSR_IDX_W'(4);

   localparam logic       CMD_DRIFT = 1'b0;
   localparam logic       CMD_KICK  = 1'b1;
   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;

   localparam logic [TS_W-1:0]    TIME_STEP_RESET  = TS_W'(0);
   localparam logic [SCALE_W-1:0] VSCALE_RESET     = SCALE_W'(65536);
   localparam logic [LIM_W-1:0]   MAX_OFFSET_RESET = LIM_W'(98304);

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic signed [PROD_W-1:0]     prod_type;

   localparam word_type WORD_MAX = word_type'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam word_type WORD_MIN = word_type'({1'b1, {(DATA_WIDTH-1){1'b0}}});

   typedef enum logic [1:0] {
      OP_PASS,
      OP_DRIFT,
      OP_KICK
   } op_type;

   typedef struct packed {
      op_type               op;
      word_type             position;
      word_type             velocity;
      word_type             force_in;
      word_type             force_new;
      word_type             force_sum;
      logic [DTM_W-1:0]     dt_over_mass;
      logic [TS_W-1:0]      time_step;
      logic [COEF_W-1:0]    drift_coef;
      logic [SCALE_W-1:0]   vel_scale;
      logic [LIM_W-1:0]     max_offset;
   } entry_type;

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[DATA_WIDTH-1:0]);
   endfunction

   // Floor shift of a signed product, saturated to one word.
   function automatic word_type shift_sat(input prod_type p, input int unsigned sh);
      prod_type q;
      q = p >>> sh;
      if ((q[PROD_W-1:DATA_WIDTH-1] != '0) && (q[PROD_W-1:DATA_WIDTH-1] != '1)) begin
         return q[PROD_W-1] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(q[DATA_WIDTH-1:0]);
   endfunction

endpackage

// ----- design/vvau_front.sv -----
// Front end: control registers, command classification and per-item coefficient prep.
`timescale 1ns / 1ps

module vvau_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [vvau_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vvau_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_cmd,
   input  logic                                req_movable,
   input  logic [1:0]                          req_axis,
   input  vvau_pkg::word_type                  req_position_in,
   input  vvau_pkg::word_type                  req_velocity_in,
   input  vvau_pkg::word_type                  req_force_in,
   input  vvau_pkg::word_type                  req_new_force,
   input  logic [vvau_pkg::DTM_W-1:0]          req_dt_over_mass,
   output vvau_pkg::entry_type                 entry
);

   logic [vvau_pkg::TS_W-1:0]      time_step_ff;
   logic [vvau_pkg::SCALE_W-1:0]   vscale_x_ff;
   logic [vvau_pkg::SCALE_W-1:0]   vscale_y_ff;
   logic [vvau_pkg::SCALE_W-1:0]   vscale_z_ff;
   logic [vvau_pkg::LIM_W-1:0]     max_offset_ff;

   logic [vvau_pkg::RAWCOEF_W-1:0] coef_raw;
   logic [vvau_pkg::RAWCOEF_W-1:0] coef_shifted;
   logic [vvau_pkg::COEF_W-1:0]    coef;
   logic [vvau_pkg::SCALE_W-1:0]   scale_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= vvau_pkg::TIME_STEP_RESET;
         vscale_x_ff   <= vvau_pkg::VSCALE_RESET;
         vscale_y_ff   <= vvau_pkg::VSCALE_RESET;
         vscale_z_ff   <= vvau_pkg::VSCALE_RESET;
         max_offset_ff <= vvau_pkg::MAX_OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            vvau_pkg::CSR_TIME_STEP:  time_step_ff  <= csr_wdata[vvau_pkg::TS_W-1:0];
            vvau_pkg::CSR_VSCALE_X:   vscale_x_ff   <= csr_wdata[vvau_pkg::SCALE_W-1:0];
            vvau_pkg::CSR_VSCALE_Y:   vscale_y_ff   <= csr_wdata[vvau_pkg::SCALE_W-1:0];
            vvau_pkg::CSR_VSCALE_Z:   vscale_z_ff   <= csr_wdata[vvau_pkg::SCALE_W-1:0];
            vvau_pkg::CSR_MAX_OFFSET: max_offset_ff <= csr_wdata[vvau_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Drift coefficient dt * dt/m, back in Q format, clipped to 32 bits unsigned.
   always_comb begin
      coef_raw     = vvau_pkg::RAWCOEF_W'(time_step_ff) * vvau_pkg::RAWCOEF_W'(req_dt_over_mass);
      coef_shifted = coef_raw >> vvau_pkg::FRAC_BITS;
      if (coef_shifted[vvau_pkg::RAWCOEF_W-1:vvau_pkg::COEF_W] != '0) begin
         coef = '1;
      end else begin
         coef = coef_shifted[vvau_pkg::COEF_W-1:0];
      end
   end

   always_comb begin
      unique case (req_axis)
         vvau_pkg::AXIS_X: scale_sel = vscale_x_ff;
         vvau_pkg::AXIS_Y: scale_sel = vscale_y_ff;
         default:          scale_sel = vscale_z_ff;
      endcase
   end

   always_comb begin
      if (!req_movable) begin
         entry.op = vvau_pkg::OP_PASS;
      end else if (req_cmd == vvau_pkg::CMD_KICK) begin
         entry.op = vvau_pkg::OP_KICK;
      end else begin
         entry.op = vvau_pkg::OP_DRIFT;
      end
      entry.position     = req_position_in;
      entry.velocity     = req_velocity_in;
      entry.force_in     = req_force_in;
      entry.force_new    = req_new_force;
      entry.force_sum    = vvau_pkg::sat_add(req_force_in, req_new_force);
      entry.dt_over_mass = req_dt_over_mass;
      entry.time_step    = time_step_ff;
      entry.drift_coef   = coef;
      entry.vel_scale    = scale_sel;
      entry.max_offset   = max_offset_ff;
   end

endmodule

// ----- design/vvau_queue.sv -----
// Short FIFO of prepared beats between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps

module vvau_queue #(
   parameter int DEPTH = vvau_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  vvau_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop,
   output vvau_pkg::entry_type  pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vvau_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not advance on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) || (count_ff == CNT_W'(DEPTH))) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- design/vvau_back.sv -----
// Back end: four-stage multiply, shift, saturate and clamp pipeline with output register.
`timescale 1ns / 1ps

module vvau_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_pop,
   input  vvau_pkg::entry_type  in_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vvau_pkg::word_type   rsp_position_out,
   output vvau_pkg::word_type   rsp_velocity_out,
   output vvau_pkg::word_type   rsp_force_out
);

   localparam int PA_W = vvau_pkg::DATA_WIDTH + vvau_pkg::TS_W + 1;
   localparam int PK_W = vvau_pkg::DATA_WIDTH + vvau_pkg::DTM_W + 1;
   localparam int PV_W = vvau_pkg::DATA_WIDTH + vvau_pkg::SCALE_W + 1;

   logic advance;

   // stage 1: v*dt and (f+fn)*dt/m
   logic                         s1_valid_ff;
   vvau_pkg::op_type             s1_op_ff;
   vvau_pkg::word_type           s1_p_ff, s1_v_ff, s1_f_ff, s1_fn_ff;
   logic [vvau_pkg::COEF_W-1:0]  s1_coef_ff;
   logic [vvau_pkg::SCALE_W-1:0] s1_scale_ff;
   logic [vvau_pkg::LIM_W-1:0]   s1_lim_ff;
   logic signed [PA_W-1:0]       s1_prod_a_ff, s1_prod_a_in;
   logic signed [PK_W-1:0]       s1_prod_k_ff, s1_prod_k_in;

   // stage 2: f*coef, velocity half kick
   logic                         s2_valid_ff;
   vvau_pkg::op_type             s2_op_ff;
   vvau_pkg::word_type           s2_p_ff, s2_v_ff, s2_f_ff, s2_fn_ff;
   logic [vvau_pkg::SCALE_W-1:0] s2_scale_ff;
   logic [vvau_pkg::LIM_W-1:0]   s2_lim_ff;
   vvau_pkg::word_type           s2_term_a_ff, s2_term_a_in;
   vvau_pkg::prod_type           s2_prod_b_ff, s2_prod_b_in;
   vvau_pkg::word_type           s2_vk_ff, s2_vk_in;

   // stage 3: clamped offset, damped velocity product
   logic                         s3_valid_ff;
   vvau_pkg::op_type             s3_op_ff;
   vvau_pkg::word_type           s3_p_ff, s3_v_ff, s3_f_ff, s3_fn_ff;
   vvau_pkg::word_type           s3_off_ff, s3_off_in;
   logic signed [PV_W-1:0]       s3_prod_v_ff, s3_prod_v_in;

   // stage 4: output register
   logic                         s4_valid_ff;
   vvau_pkg::word_type           s4_p_ff, s4_p_in;
   vvau_pkg::word_type           s4_v_ff, s4_v_in;
   vvau_pkg::word_type           s4_f_ff, s4_f_in;

   vvau_pkg::word_type           off_sum;
   vvau_pkg::word_type           lim_pos;
   vvau_pkg::word_type           lim_neg;

   // whole pipeline moves together; hold when the result beat is stalled
   assign advance = !s4_valid_ff || rsp_ready;
   assign in_pop  = advance && in_valid;

   always_comb begin
      s1_prod_a_in = PA_W'($signed(in_entry.velocity))
                   * PA_W'($signed({1'b0, in_entry.time_step}));
      s1_prod_k_in = PK_W'($signed(in_entry.force_sum))
                   * PK_W'($signed({1'b0, in_entry.dt_over_mass}));
   end

   always_comb begin
      s2_term_a_in = vvau_pkg::shift_sat(vvau_pkg::prod_type'(s1_prod_a_ff),
                                         vvau_pkg::FRAC_BITS);
      s2_prod_b_in = vvau_pkg::PROD_W'($signed(s1_f_ff))
                   * vvau_pkg::PROD_W'($signed({1'b0, s1_coef_ff}));
      s2_vk_in     = vvau_pkg::sat_add(s1_v_ff,
                        vvau_pkg::shift_sat(vvau_pkg::prod_type'(s1_prod_k_ff),
                                            vvau_pkg::FRAC_BITS + 1));
   end

   always_comb begin
      lim_pos = vvau_pkg::word_type'({{(vvau_pkg::DATA_WIDTH-vvau_pkg::LIM_W){1'b0}},
                                      s2_lim_ff});
      lim_neg = -lim_pos;
      off_sum = vvau_pkg::sat_add(s2_term_a_ff,
                                  vvau_pkg::shift_sat(s2_prod_b_ff, vvau_pkg::FRAC_BITS));
      if (off_sum > lim_pos) begin
         s3_off_in = lim_pos;
      end else if (off_sum < lim_neg) begin
         s3_off_in = lim_neg;
      end else begin
         s3_off_in = off_sum;
      end
      s3_prod_v_in = PV_W'($signed(s2_vk_ff)) * PV_W'($signed({1'b0, s2_scale_ff}));
   end

   always_comb begin
      s4_p_in = s3_p_ff;
      s4_v_in = s3_v_ff;
      s4_f_in = s3_f_ff;
      if (s3_op_ff == vvau_pkg::OP_DRIFT) begin
         s4_p_in = vvau_pkg::sat_add(s3_p_ff, s3_off_ff);
      end else if (s3_op_ff == vvau_pkg::OP_KICK) begin
         s4_v_in = vvau_pkg::shift_sat(vvau_pkg::prod_type'(s3_prod_v_ff),
                                       vvau_pkg::FRAC_BITS);
         s4_f_in = s3_fn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff     <= in_entry.op;
         s1_p_ff      <= in_entry.position;
         s1_v_ff      <= in_entry.velocity;
         s1_f_ff      <= in_entry.force_in;
         s1_fn_ff     <= in_entry.force_new;
         s1_coef_ff   <= in_entry.drift_coef;
         s1_scale_ff  <= in_entry.vel_scale;
         s1_lim_ff    <= in_entry.max_offset;
         s1_prod_a_ff <= s1_prod_a_in;
         s1_prod_k_ff <= s1_prod_k_in;

         s2_op_ff     <= s1_op_ff;
         s2_p_ff      <= s1_p_ff;
         s2_v_ff      <= s1_v_ff;
         s2_f_ff      <= s1_f_ff;
         s2_fn_ff     <= s1_fn_ff;
         s2_scale_ff  <= s1_scale_ff;
         s2_lim_ff    <= s1_lim_ff;
         s2_term_a_ff <= s2_term_a_in;
         s2_prod_b_ff <= s2_prod_b_in;
         s2_vk_ff     <= s2_vk_in;

         s3_op_ff     <= s2_op_ff;
         s3_p_ff      <= s2_p_ff;
         s3_v_ff      <= s2_v_ff;
         s3_f_ff      <= s2_f_ff;
         s3_fn_ff     <= s2_fn_ff;
         s3_off_ff    <= s3_off_in;
         s3_prod_v_ff <= s3_prod_v_in;

         s4_p_ff      <= s4_p_in;
         s4_v_ff      <= s4_v_in;
         s4_f_ff      <= s4_f_in;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_position_out = s4_p_ff;
   assign rsp_velocity_out = s4_v_ff;
   assign rsp_force_out    = s4_f_ff;

endmodule

// ----- design/velocity_verlet_axis_update.sv -----
// Velocity Verlet axis update: front end, beat queue and arithmetic pipeline.
// A request beat is written to the queue, then registered through stages 1 to 4.
// Throughput: one beat per cycle while the result side is ready; the queue and
// the four-stage multiply pipeline both sustain one item a cycle, and the queue
// absorbs result-side stalls until it fills, after which req_ready drops.
// Reset: synchronous; clears the queue and pipeline valid state and loads the
// control registers with dt 0, velocity scales 1.0 and offset clamp 1.5.
`timescale 1ns / 1ps

module velocity_verlet_axis_update #(
   parameter int QUEUE_DEPTH = vvau_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [vvau_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vvau_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic                            req_movable,
   input  logic [1:0]                      req_axis,
   input  vvau_pkg::word_type              req_position_in,
   input  vvau_pkg::word_type              req_velocity_in,
   input  vvau_pkg::word_type              req_force_in,
   input  vvau_pkg::word_type              req_new_force,
   input  logic [vvau_pkg::DTM_W-1:0]      req_dt_over_mass,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output vvau_pkg::word_type              rsp_position_out,
   output vvau_pkg::word_type              rsp_velocity_out,
   output vvau_pkg::word_type              rsp_force_out
);

   vvau_pkg::entry_type front_entry;
   vvau_pkg::entry_type queue_entry;
   logic                queue_valid;
   logic                queue_pop;

   vvau_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_cmd),
      .req_movable      (req_movable),
      .req_axis         (req_axis),
      .req_position_in  (req_position_in),
      .req_velocity_in  (req_velocity_in),
      .req_force_in     (req_force_in),
      .req_new_force    (req_new_force),
      .req_dt_over_mass (req_dt_over_mass),
      .entry            (front_entry)
   );

   vvau_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_entry  (queue_entry)
   );

   vvau_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (queue_valid),
      .in_pop           (queue_pop),
      .in_entry         (queue_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position_out (rsp_position_out),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_force_out    (rsp_force_out)
   );

endmodule
